FILE: src/assert_macros.svh
// Assertion macros for the top level, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BMH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define BMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/bmh_pkg.sv
// Types, codes and constants shared by the heap controller, datapath and top level.
package bmh_pkg;

   localparam int DATA_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int FILL_W       = 7;
   localparam int DEF_CAPACITY = 64;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;      // latch the request and start position
      logic                rd_ends;      // read the root and the last element
      logic                rd_children;  // read both children of the position
      logic                take_ends;    // keep the root, hold the last element
      logic                move_up;      // parent moves down into the position
      logic                move_down;    // larger child moves up into the position
      logic                put_hold;     // held value settles at the position
      logic                count_up;     // one more element held
      logic                load_rsp;     // fill the result registers
      logic [STATUS_W-1:0] rsp_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_gt;
      logic dn_leaf;
      logic dn_gt;
   } status_type;

endpackage

FILE: src/bmh_ram.sv
// Generic RAM with one write port and two registered read ports.
module bmh_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: src/bmh_datapath.sv
// Heap datapath: element store, count, sift position, held value and result registers.
module bmh_datapath import bmh_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 sts,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic signed [DATA_W-1:0]   rsp_max_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FILL_W-1:0]          rsp_fill_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   logic [CW-1:0]              count_ff, count_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic signed [DATA_W-1:0]   hold_ff, hold_in;
   logic signed [DATA_W-1:0]   result_ff, result_in;
   logic signed [DATA_W-1:0]   max_value_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic [FILL_W-1:0]          fill_ff;

   logic [IW-1:0]              left_idx, right_idx, count_ext;
   logic [AW-1:0]              parent_idx, last_idx, pick_idx;
   logic [AW-1:0]              rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]          rd_data_a, rd_data_b;
   logic signed [DATA_W-1:0]   left_val, right_val, pick_val;
   logic                       right_ok, pick_right;
   logic                       wr_en;
   logic [DATA_W-1:0]          wr_data;

   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + IW'(1);
   assign count_ext  = IW'(count_ff);
   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);
   assign last_idx   = AW'(count_ff - CW'(1));

   assign rd_addr_a = cmd.rd_children ? left_idx[AW-1:0] :
                      (cmd.rd_ends ? '0 : parent_idx);
   assign rd_addr_b = cmd.rd_ends ? last_idx : right_idx[AW-1:0];

   assign left_val   = $signed(rd_data_a);
   assign right_val  = $signed(rd_data_b);
   // The right child counts only when it lies inside the heap.
   assign right_ok   = right_idx < count_ext;
   assign pick_right = right_ok && (right_val > left_val);
   assign pick_val   = pick_right ? right_val : left_val;
   assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   assign sts.full     = count_ff == CW'(CAPACITY);
   assign sts.empty    = count_ff == '0;
   assign sts.pos_zero = pos_ff == '0;
   assign sts.up_gt    = hold_ff > left_val;
   assign sts.dn_leaf  = left_idx >= count_ext;
   assign sts.dn_gt    = pick_val > hold_ff;

   assign wr_en = cmd.move_up || cmd.move_down || cmd.put_hold;

   always_comb begin
      wr_data = hold_ff;
      if (cmd.move_up) begin
         wr_data = rd_data_a;
      end else if (cmd.move_down) begin
         wr_data = pick_val;
      end
   end

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      hold_in   = hold_ff;
      result_in = result_ff;
      if (cmd.capture) begin
         pos_in    = count_ff[AW-1:0];
         hold_in   = req_value;
         result_in = '0;
      end
      if (cmd.take_ends) begin
         pos_in    = '0;
         hold_in   = right_val;
         result_in = left_val;
         count_in  = count_ff - CW'(1);
      end
      if (cmd.move_up) begin
         pos_in = parent_idx;
      end
      if (cmd.move_down) begin
         pos_in = pick_idx;
      end
      if (cmd.count_up) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      hold_ff   <= hold_in;
      result_ff <= result_in;
      if (cmd.load_rsp) begin
         max_value_ff <= result_ff;
         status_ff    <= cmd.rsp_code;
         fill_ff      <= FILL_W'(count_ff);
      end
   end

   bmh_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign rsp_max_value  = max_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_fill_count = fill_ff;

endmodule

FILE: src/bmh_ctrl.sv
// Heap controller: sequences inserts, extracts and sifting, and owns both handshakes.
module bmh_ctrl import bmh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP_CHK = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_EXT    = 3'd3;
   localparam logic [2:0] S_DN_CHK = 3'd4;
   localparam logic [2:0] S_DN_CMP = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rsp_code = code_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               code_in     = ST_OK;
               if (req_op == OP_INSERT) begin
                  if (sts.full) begin
                     code_in  = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_UP_CHK;
                  end
               end else begin
                  if (sts.empty) begin
                     code_in  = ST_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     cmd.rd_ends = 1'b1;
                     state_in    = S_EXT;
                  end
               end
            end
         end
         S_UP_CHK: begin
            // The parent read is issued here; its data arrives next cycle.
            if (sts.pos_zero) begin
               cmd.put_hold = 1'b1;
               cmd.count_up = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (sts.up_gt) begin
               cmd.move_up = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.put_hold = 1'b1;
               cmd.count_up = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_EXT: begin
            cmd.take_ends = 1'b1;
            state_in      = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (sts.dn_leaf) begin
               cmd.put_hold = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.rd_children = 1'b1;
               state_in        = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (sts.dn_gt) begin
               cmd.move_down = 1'b1;
               state_in      = S_DN_CHK;
            end else begin
               cmd.put_hold = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            // The result registers are reloaded only once the previous transaction has left.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/binary_max_heap.sv
// Top level of the max-priority queue held as a binary heap in a RAM.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_ready   req_op, req_value
//   rsp      out        rsp_valid / rsp_ready   rsp_max_value, rsp_status, rsp_fill_count
//
// An insert on a full heap or an extract on an empty one goes straight to its result; else
// an insert climbs to the root or a larger parent and an extract sinks to a leaf or to no
// larger child, at most log2(CAPACITY) levels, one RAM read and one compare-and-write each.
// Reset clears the element count and both handshakes; the RAM needs no clearing pass.
// A stalled result holds in its register while the next transaction is already taken,
// and that transaction waits in its final state until the register is free.
`include "assert_macros.svh"

module binary_max_heap import bmh_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_max_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [FILL_W-1:0]        rsp_fill_count
);

   cmd_type    cmd;
   status_type sts;

   logic req_take;
   logic store_wr;
   logic rsp_is_empty;
   logic rsp_is_full;
   logic empty_rsp_ok;
   logic full_rsp_ok;

   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmh_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_value      (req_value),
      .rsp_max_value  (rsp_max_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   assign req_take     = req_valid && req_ready;
   assign store_wr     = cmd.move_up || cmd.move_down || cmd.put_hold;
   assign rsp_is_empty = rsp_valid && rsp_status == ST_EMPTY;
   assign rsp_is_full  = rsp_valid && rsp_status == ST_FULL;
   assign empty_rsp_ok = rsp_max_value == '0 && rsp_fill_count == '0;
   assign full_rsp_ok  = rsp_max_value == '0 && rsp_fill_count == FILL_W'(CAPACITY);

   `BMH_ASSERT(a_busy, clock, reset, req_take |=> !req_ready, "request taken while busy")
   `BMH_ASSERT(a_idle_write, clock, reset, store_wr |-> !req_ready, "store written in idle")
   `BMH_ASSERT(a_empty_rsp, clock, reset, rsp_is_empty |-> empty_rsp_ok, "bad empty result")
   `BMH_ASSERT(a_full_rsp, clock, reset, rsp_is_full |-> full_rsp_ok, "bad full result")

endmodule
